@@ rtl/b64e_pkg.sv @@
// b64e_pkg: types, constants and the alphabet function of the base64 stream encoder
// no dependencies; used by every other file of the block

package b64e_pkg;

	localparam int SEXTET_W = 6;
	localparam int CHAR_W   = 7;
	localparam int SLOTS    = 4;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CHAR_W-1:0] PAD_CHAR   = 7'd61;
	localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'd65;
	localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'd71;
	localparam logic [CHAR_W-1:0] CHAR_DIGIT = 7'd4;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'd43;
	localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'd47;

	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_THIRD  = 3'b100
	} phase_t;

	// one accepted byte turned into up to four output characters
	typedef struct packed {
		logic [SLOTS-1:0][SEXTET_W-1:0] sextet;
		logic [SLOTS-1:0]               pad;
		logic [SLOT_W-1:0]              last_slot;
		logic                           fin;
	} job_t;

	function automatic logic [CHAR_W-1:0] sextet_to_ascii(input logic [SEXTET_W-1:0] v);
		logic [CHAR_W-1:0] w;
		begin
			w = {1'b0, v};
			if (v < 6'd26) begin
				sextet_to_ascii = w + CHAR_UPPER;
			end else if (v < 6'd52) begin
				sextet_to_ascii = w + CHAR_LOWER;
			end else if (v < 6'd62) begin
				sextet_to_ascii = w - CHAR_DIGIT;
			end else if (v == 6'd62) begin
				sextet_to_ascii = CHAR_PLUS;
			end else begin
				sextet_to_ascii = CHAR_SLASH;
			end
		end
	endfunction

endpackage

@@ rtl/b64e_stream_if.sv @@
// b64e_byte_if and b64e_char_if: valid/ready channels of the base64 stream encoder
// depends on b64e_pkg for field widths

interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
	logic                         valid;
	logic                         ready;
	logic [b64e_pkg::CHAR_W-1:0]  out_char;
	logic                         last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

@@ rtl/b64e_front.sv @@
// b64e_front: accepts raw bytes, tracks group phase and carry bits, builds one job per byte
// depends on b64e_pkg and b64e_byte_if

module b64e_front (
	input  logic                clk,
	input  logic                arst_n,
	b64e_byte_if.sink           byte_stream,
	output logic                push_valid,
	output b64e_pkg::job_t      push_job,
	input  logic                push_ready
);
	import b64e_pkg::*;

	phase_t         phase_q;
	phase_t         phase_d;
	logic [3:0]     carry_q;
	logic [3:0]     carry_d;
	job_t           job;
	logic           transfer;
	logic [7:0]     b;
	logic           fin;

	assign b          = byte_stream.data_byte;
	assign fin        = byte_stream.last_byte;
	assign byte_stream.ready = push_ready;
	assign push_valid = byte_stream.valid;
	assign push_job   = job;
	assign transfer   = byte_stream.valid && push_ready;

	always_comb begin
		job           = '0;
		job.fin       = fin;
		phase_d       = PH_FIRST;
		carry_d       = 4'd0;
		case (phase_q)
			PH_SECOND: begin
				job.sextet[0] = {carry_q[1:0], b[7:4]};
				if (fin) begin
					job.sextet[1] = {b[3:0], 2'b00};
					job.pad[2]    = 1'b1;
					job.last_slot = 2'd2;
				end else begin
					carry_d = b[3:0];
					phase_d = PH_THIRD;
				end
			end
			PH_THIRD: begin
				job.sextet[0] = {carry_q, b[7:6]};
				job.sextet[1] = b[5:0];
				job.last_slot = 2'd1;
			end
			default: begin
				job.sextet[0] = b[7:2];
				if (fin) begin
					job.sextet[1] = {b[1:0], 4'b0000};
					job.pad[2]    = 1'b1;
					job.pad[3]    = 1'b1;
					job.last_slot = 2'd3;
				end else begin
					carry_d = {2'b00, b[1:0]};
					phase_d = PH_SECOND;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			carry_q <= 4'd0;
		end else if (transfer) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

endmodule

@@ rtl/b64e_queue.sv @@
// b64e_queue: two-entry job queue between the front and the back
// depends on b64e_pkg

module b64e_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  b64e_pkg::job_t      push_job,
	output logic                push_ready,
	output logic                pop_valid,
	output b64e_pkg::job_t      pop_job,
	input  logic                pop_ready
);
	import b64e_pkg::*;

	job_t               mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_job    = mem[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/b64e_back.sv @@
// b64e_back: walks the slots of each job and drives one character per cycle,
// while a job is waiting and char_stream is ready; depends on b64e_pkg and b64e_char_if

module b64e_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	input  b64e_pkg::job_t      pop_job,
	output logic                pop_ready,
	b64e_char_if.source         char_stream
);
	import b64e_pkg::*;

	job_t               cur_q;
	logic               cur_valid_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic               advance;
	logic               job_done;
	logic [CHAR_W-1:0]  char_d;

	assign advance  = cur_valid_q && (!out_valid_q || char_stream.ready);
	assign job_done = slot_q == cur_q.last_slot;
	assign pop_ready = !cur_valid_q || (advance && job_done);
	assign char_d   = cur_q.pad[slot_q] ? PAD_CHAR : sextet_to_ascii(cur_q.sextet[slot_q]);

	assign char_stream.valid     = out_valid_q;
	assign char_stream.out_char  = char_q;
	assign char_stream.last_char = last_q;

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			cur_q <= pop_job;
		end
		if (advance) begin
			char_q <= char_d;
			last_q <= cur_q.fin && job_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_ready) begin
				cur_valid_q <= pop_valid;
				slot_q      <= '0;
			end else if (advance) begin
				slot_q <= slot_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (char_stream.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/base64_stream_encoder.sv @@
// base64_stream_encoder: top level of the streaming base64 encoder
// depends on b64e_pkg, b64e_byte_if, b64e_char_if, b64e_front, b64e_queue, b64e_back
//
// byte_stream takes one raw byte per transfer with last_byte set on the final
// byte of a message; char_stream gives one ascii character per transfer, with
// last_char set on the final character (including '=' padding).
// a byte yields one character at the start or middle of a group, two at its end,
// and three or four when the message ends early in a group.
// the front classifies each byte in its transfer cycle and stores a job in a
// two-entry queue; the back sends one character per cycle, while char_stream
// is ready, from an output register. a byte's first character passes through
// the queue entry, the back's job register and the output register; the back
// sets the throughput of the encoder.
// when char_stream stalls, the output register holds, the back stops, and
// byte_stream.ready drops once the queue is full; the front keeps taking
// bytes while the queue has room.
// reset clears group phase, carry bits, queue and output valid; no clearing pass.

module base64_stream_encoder (
	input  logic        clk,
	input  logic        arst_n,
	b64e_byte_if.sink   byte_stream,
	b64e_char_if.source char_stream
);
	import b64e_pkg::*;

	logic   push_valid;
	logic   push_ready;
	job_t   push_job;
	logic   pop_valid;
	logic   pop_ready;
	job_t   pop_job;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_stream(byte_stream),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	b64e_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job),
		.pop_ready  (pop_ready)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job),
		.pop_ready  (pop_ready),
		.char_stream(char_stream)
	);

endmodule
